FILE: design/wpm_pkg.sv
// Package for the wildcard pattern matcher: sizes, action codes, command type
// and the case-folding function. It depends on nothing else.
package wpm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int POS_W       = MAX_PATTERN + 1;
    localparam int SYM_W       = 8;
    localparam int ACT_W       = 2;

    localparam logic [SYM_W-1:0] SYM_ANY_ONE = 8'h3F;
    localparam logic [SYM_W-1:0] SYM_ANY_RUN = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_UPPER_A = 8'h41;
    localparam logic [SYM_W-1:0] SYM_UPPER_Z = 8'h5A;
    localparam logic [SYM_W-1:0] SYM_CASE_OFS = 8'h20;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_TEXT   = 2'd2,
        ACT_END    = 2'd3
    } t_action;

    typedef struct packed {
        t_action          act;
        logic [SYM_W-1:0] sym;
        logic             is_run;
        logic             is_one;
    } t_cmd;

    function automatic logic [SYM_W-1:0] fold(input logic [SYM_W-1:0] c, input logic ci);
        logic [SYM_W-1:0] r;
        r = c;
        if (ci && c >= SYM_UPPER_A && c <= SYM_UPPER_Z) begin
            r = c + SYM_CASE_OFS;
        end
        return r;
    endfunction

endpackage

FILE: design/wpm_in_if.sv
// Input item channel of the wildcard pattern matcher: valid, ready, action, symbol.
// Depends on wpm_pkg.
interface wpm_in_if;
    import wpm_pkg::*;
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [SYM_W-1:0] symbol;
    modport source (output valid, output action, output symbol, input ready);
    modport sink   (input valid, input action, input symbol, output ready);
endinterface

FILE: design/wpm_out_if.sv
// Result channel of the wildcard pattern matcher: valid, ready, matched and the
// overflow flag. It has no dependencies.
interface wpm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;
    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

FILE: design/wpm_cfg_if.sv
// Configuration write channel of the wildcard pattern matcher: valid, ready and
// the case_insensitive bit. It has no dependencies.
interface wpm_cfg_if;
    logic valid;
    logic ready;
    logic case_insensitive;
    modport source (output valid, output case_insensitive, input ready);
    modport sink   (input valid, input case_insensitive, output ready);
endinterface

FILE: design/wpm_front.sv
// Front end: takes input transfers, decodes the action and flags wildcard
// symbols, and holds one decoded command for the queue. Depends on wpm_pkg, wpm_in_if.
module wpm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wpm_in_if.sink        i_item,
    output logic          o_push_valid,
    output wpm_pkg::t_cmd o_push_cmd,
    input  logic          i_push_ready
);
    import wpm_pkg::*;

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign i_item.ready = !r_valid || i_push_ready;
    assign accept       = i_item.valid && i_item.ready;

    always_comb begin
        n_cmd.act    = t_action'(i_item.action);
        n_cmd.sym    = i_item.symbol;
        n_cmd.is_run = (i_item.symbol == SYM_ANY_RUN);
        n_cmd.is_one = (i_item.symbol == SYM_ANY_ONE);
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;
endmodule

FILE: design/wpm_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on wpm_pkg.
module wpm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  wpm_pkg::t_cmd i_push_cmd,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output wpm_pkg::t_cmd o_pop_cmd,
    input  logic          i_pop_ready
);
    import wpm_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_cmd    = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wp  = push ? !r_wp : r_wp;
        n_rp  = pop ? !r_rp : r_rp;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end
endmodule

FILE: design/wpm_back.sv
// Back end: pattern store, live-position automaton, configuration register and
// the result register. Depends on wpm_pkg, wpm_out_if, wpm_cfg_if.
module wpm_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  wpm_pkg::t_cmd i_cmd,
    output logic          o_cmd_ready,
    wpm_cfg_if.sink       i_cfg,
    wpm_out_if.source     o_result
);
    import wpm_pkg::*;

    logic [SYM_W-1:0] r_store [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] r_star;
    logic [MAX_PATTERN-1:0] r_any;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic [POS_W-1:0] r_live;
    logic [POS_W-1:0] n_live;
    logic             r_ovf;
    logic             n_ovf;
    logic             r_ci;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_matched;
    logic             r_out_ovf;

    logic [MAX_PATTERN-1:0] in_pat;
    logic [MAX_PATTERN-1:0] step_v;
    logic [POS_W-1:0] star_v;
    logic [POS_W-1:0] live_star;
    logic [POS_W-1:0] carry_sum;
    logic [POS_W-1:0] closed;
    logic [POS_W-1:0] text_next;
    logic [SYM_W-1:0] sym_fold;
    logic             pop;
    logic             store_wr;
    logic             has_room;

    assign sym_fold = fold(i_cmd.sym, r_ci);

    // Per-position decode: only positions below the pattern length take part.
    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_pos
        assign in_pat[g] = (r_len > LEN_W'(g));
        assign step_v[g] = in_pat[g] && !r_star[g]
                           && (r_any[g] || fold(r_store[g], r_ci) == sym_fold);
        assign star_v[g] = in_pat[g] && r_star[g];
    end
    assign star_v[POS_W-1] = 1'b0;

    // Star closure as a carry chain: a live star generates, an unlived star propagates.
    assign live_star = r_live & star_v;
    assign carry_sum = star_v + live_star;
    assign closed    = r_live | (carry_sum ^ star_v ^ live_star);
    assign text_next = (closed & star_v)
                       | {step_v & closed[MAX_PATTERN-1:0], 1'b0};

    assign has_room    = (r_len < LEN_W'(MAX_PATTERN));
    assign o_cmd_ready = (i_cmd.act != ACT_END) || !r_out_valid || o_result.ready;
    assign pop         = i_cmd_valid && o_cmd_ready;
    assign store_wr    = pop && (i_cmd.act == ACT_APPEND) && has_room;

    always_comb begin
        n_len       = r_len;
        n_live      = r_live;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !o_result.ready;
        if (pop) begin
            case (i_cmd.act)
                ACT_CLEAR: begin
                    n_len  = '0;
                    n_ovf  = 1'b0;
                    n_live = POS_W'(1);
                end
                ACT_APPEND: begin
                    if (has_room) begin
                        n_len = r_len + LEN_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_live = POS_W'(1);
                end
                ACT_TEXT: begin
                    n_live = text_next;
                end
                ACT_END: begin
                    n_live      = POS_W'(1);
                    n_out_valid = 1'b1;
                end
                default: begin
                    n_live = r_live;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_live      <= POS_W'(1);
            r_ovf       <= 1'b0;
            r_ci        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_live      <= n_live;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_ci <= i_cfg.case_insensitive;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            r_store[r_len[IDX_W-1:0]] <= i_cmd.sym;
            r_star[r_len[IDX_W-1:0]]  <= i_cmd.is_run;
            r_any[r_len[IDX_W-1:0]]   <= i_cmd.is_one;
        end
        if (pop && i_cmd.act == ACT_END) begin
            r_matched <= closed[r_len];
            r_out_ovf <= r_ovf;
        end
    end

    assign i_cfg.ready               = 1'b1;
    assign o_result.valid            = r_out_valid;
    assign o_result.matched          = r_matched;
    assign o_result.pattern_overflow = r_out_ovf;
endmodule

FILE: design/wildcard_pattern_matcher.sv
// Top level of the wildcard pattern matcher: front end, command queue and back end.
// Depends on wpm_pkg, wpm_in_if, wpm_out_if, wpm_cfg_if, wpm_front, wpm_queue, wpm_back.
//
// Use: i_item carries one action and one byte per transfer. Action clear empties
// the pattern and the overflow flag; append adds a pattern byte, where '*' matches
// any run of bytes (also none) and '?' any one byte; text feeds one byte to the
// automaton; end of text produces one transfer on o_result with matched and the
// sticky pattern_overflow flag, and restarts matching for the next text.
// Appending more than MAX_PATTERN bytes drops the extras and sets the flag.
// i_cfg writes case_insensitive, which folds ASCII letters before literal compares;
// it is always ready and should only be written while the block is idle.
// Throughput is one item per cycle while no result waits on a stalled receiver:
// every pattern position is updated in parallel and the star closure is a single
// carry chain, so the automaton update in the back end sets the rate. An
// end-of-text item passes through the front register, the queue and the result
// register on its way to o_result.
// After reset the pattern is empty, the flag is clear, case folding is off and no
// result is pending. When the receiver stalls, the result register holds its
// value, the two-entry queue and the front register fill, and i_item.ready falls
// only once all of them are full; non-result items keep flowing meanwhile.
module wildcard_pattern_matcher (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wpm_in_if.sink    i_item,
    wpm_cfg_if.sink   i_cfg,
    wpm_out_if.source o_result
);
    import wpm_pkg::*;

    logic push_valid;
    logic push_ready;
    t_cmd push_cmd;
    logic pop_valid;
    logic pop_ready;
    t_cmd pop_cmd;

    wpm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    wpm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop_ready  (pop_ready)
    );

    wpm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (pop_valid),
        .i_cmd       (pop_cmd),
        .o_cmd_ready (pop_ready),
        .i_cfg       (i_cfg),
        .o_result    (o_result)
    );
endmodule

FILE: test/wpm_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the wildcard pattern matcher testbench: a glob automaton
// predictor and a queue of expected end-of-text verdicts. Depends on wpm_pkg.
package wpm_scoreboard_pkg;
    import wpm_pkg::*;

    class match_scoreboard;
        typedef struct packed {
            logic matched;
            logic overflow;
        } t_verdict;

        logic [SYM_W-1:0] pat [MAX_PATTERN];
        int unsigned      pat_len;
        logic [POS_W-1:0] live;
        bit               overflow_seen;
        bit               fold_on;
        t_verdict         verdict_q [$];
        int unsigned      mismatches;
        int unsigned      verdicts_checked;
        int unsigned      matches_seen;
        int unsigned      overflows_seen;

        function new();
            pat_len          = 0;
            overflow_seen    = 1'b0;
            fold_on          = 1'b0;
            mismatches       = 0;
            verdicts_checked = 0;
            matches_seen     = 0;
            overflows_seen   = 0;
            restart_scan();
        endfunction

        function void restart_scan();
            live    = '0;
            live[0] = 1'b1;
        endfunction

        function void set_fold(bit on);
            fold_on = on;
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function logic [SYM_W-1:0] to_lower(logic [SYM_W-1:0] c);
            if (fold_on && c >= SYM_UPPER_A && c <= SYM_UPPER_Z) begin
                return c + SYM_CASE_OFS;
            end
            return c;
        endfunction

        // A live position sitting on a star also enables the one after it;
        // walking upwards lets a run of stars chain through in one pass.
        function logic [POS_W-1:0] star_closure(logic [POS_W-1:0] v);
            logic [POS_W-1:0] r;
            r = v;
            for (int i = 0; i < pat_len; i++) begin
                if (r[i] && pat[i] == SYM_ANY_RUN) begin
                    r[i+1] = 1'b1;
                end
            end
            return r;
        endfunction

        function void accept_item(t_action act, logic [SYM_W-1:0] sym);
            logic [POS_W-1:0] cur;
            logic [POS_W-1:0] nxt;
            case (act)
                ACT_CLEAR: begin
                    pat_len       = 0;
                    overflow_seen = 1'b0;
                    restart_scan();
                end
                ACT_APPEND: begin
                    if (pat_len < MAX_PATTERN) begin
                        pat[pat_len] = sym;
                        pat_len++;
                    end else begin
                        overflow_seen = 1'b1;
                    end
                    restart_scan();
                end
                ACT_TEXT: begin
                    cur = star_closure(live);
                    nxt = '0;
                    for (int i = 0; i < pat_len; i++) begin
                        if (cur[i]) begin
                            if (pat[i] == SYM_ANY_RUN) begin
                                nxt[i] = 1'b1;
                            end else if (pat[i] == SYM_ANY_ONE ||
                                         to_lower(pat[i]) == to_lower(sym)) begin
                                nxt[i+1] = 1'b1;
                            end
                        end
                    end
                    live = nxt;
                end
                default: begin
                    cur = star_closure(live);
                    verdict_q.push_back('{matched: cur[pat_len], overflow: overflow_seen});
                    restart_scan();
                end
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("%0t: result error: %s", $time, what);
        endtask

        task check_verdict(logic matched, logic ovf);
            t_verdict want;
            string    diff;
            verdicts_checked++;
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result matched=%b overflow=%b",
                                          matched, ovf));
                return;
            end
            want = verdict_q.pop_front();
            diff = "";
            if (matched !== want.matched) begin
                diff = {diff, $sformatf(" matched got %b want %b", matched, want.matched)};
            end
            if (ovf !== want.overflow) begin
                diff = {diff, $sformatf(" overflow got %b want %b", ovf, want.overflow)};
            end
            if (diff != "") begin
                report_mismatch($sformatf("verdict %0d:%s", verdicts_checked, diff));
            end
            if (want.matched) begin
                matches_seen++;
            end
            if (want.overflow) begin
                overflows_seen++;
            end
        endtask
    endclass

endpackage

FILE: test/tb_wildcard_pattern_matcher.sv
`timescale 1ns / 1ps
// Self-checking testbench for wildcard_pattern_matcher: directed and random
// pattern/text streams under sender gaps and receiver stalls.
// Depends on wpm_pkg, the three channel interfaces and wpm_scoreboard_pkg.
module tb_wildcard_pattern_matcher;
    import wpm_pkg::*;
    import wpm_scoreboard_pkg::*;

    // Character constants used when building stimulus.
    localparam logic [SYM_W-1:0] LOWER_A      = 8'h61;
    localparam logic [SYM_W-1:0] LOWER_Z      = 8'h7A;
    localparam logic [SYM_W-1:0] SYM_NUL      = 8'h00;
    localparam logic [SYM_W-1:0] SYM_ALL_ONES = 8'hFF;
    localparam logic [SYM_W-1:0] SYM_HIGH_BIT = 8'h80;
    localparam logic [SYM_W-1:0] SYM_MID      = 8'h55;

    localparam int STALL_LIMIT  = 2000; // cycles without any transfer before giving up
    localparam int SETTLE_CYC   = 6;    // covers the three-stage pipeline with margin
    localparam int PHASE_ITEMS  = 212;
    localparam int HOLD_AFTER   = 400;  // input transfers before the long receiver hold
    localparam int HOLD_CYCLES  = 150;

    typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_SPARSE} t_rx_mode;

    logic clk = 1'b0;
    logic rst_n;

    wpm_in_if  item_ch ();
    wpm_cfg_if cfg_ch ();
    wpm_out_if res_ch ();

    wildcard_pattern_matcher uut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    match_scoreboard sb = new();

    int               items_accepted = 0;
    int               cfg_writes     = 0;
    int               burst_left     = 0;
    bit               gaps_on        = 1'b0;
    bit               hold_done      = 1'b0;
    logic [SYM_W-1:0] cur_pat [$];

    always #5 clk = ~clk;

    // Every accepted result is checked at the rising edge on which its
    // transfer happens; nothing is looked at while reset is applied.
    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready) begin
            sb.check_verdict(res_ch.matched, res_ch.pattern_overflow);
        end
    end

    // Watchdog: any transfer on any channel counts as progress. A lost result
    // leaves the drain loop waiting forever, which ends up here as well.
    int idle_cycles = 0;
    always @(posedge clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver back-pressure. The mode is redrawn at random whenever its random
    // run length is used up, so that stalls land on every stage of the pipeline,
    // with open stretches in between. Once, well into the random traffic, the
    // receiver holds off for a long stretch while the sender keeps offering items:
    // the result register, the queue and the front register all fill and the
    // input channel has to stall.
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       tick;
        mode      = RX_OPEN;
        mode_left = 0;
        tick      = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && items_accepted >= HOLD_AFTER) begin
                hold_done    = 1'b1;
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                tick++;
                case (mode)
                    RX_OPEN:         res_ch.ready = 1'b1;
                    RX_COIN:         res_ch.ready = 1'($urandom_range(0, 1));
                    RX_EVERY_FOURTH: res_ch.ready = (tick % 4) != 0;
                    default:         res_ch.ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offers one item from the falling edge on and returns after its transfer.
    // Valid is left high, so back-to-back items follow without a bubble; the
    // next call or a gap changes it at the following falling edge.
    task automatic push_item(t_action act, logic [SYM_W-1:0] sym);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge clk);
                item_ch.valid = 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        item_ch.valid  = 1'b1;
        item_ch.action = act;
        item_ch.symbol = sym;
        do @(posedge clk); while (!item_ch.ready);
        sb.accept_item(act, sym);
        items_accepted++;
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // Stops offering items and waits until every verdict has arrived, then
    // lets the pipeline run dry of items that produce no result.
    task automatic settle();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_fold(bit on);
        @(negedge clk);
        cfg_ch.valid            = 1'b1;
        cfg_ch.case_insensitive = on;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.set_fold(on);
        cfg_writes++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Symbols lean towards wildcards, a few letters in both cases and the
    // byte extremes, so that patterns and texts actually meet each other.
    function automatic logic [SYM_W-1:0] pick_symbol();
        case ($urandom_range(0, 9))
            0:       return SYM_ANY_RUN;
            1:       return SYM_ANY_ONE;
            2, 3, 4: return LOWER_A + SYM_W'($urandom_range(0, 3));
            5, 6:    return SYM_UPPER_A + SYM_W'($urandom_range(0, 3));
            7:       return SYM_NUL;
            8:       return SYM_ALL_ONES;
            default: return SYM_W'($urandom);
        endcase
    endfunction

    function automatic logic [SYM_W-1:0] maybe_flip_case(logic [SYM_W-1:0] p);
        if (((p >= SYM_UPPER_A && p <= SYM_UPPER_Z) || (p >= LOWER_A && p <= LOWER_Z)) &&
            $urandom_range(0, 2) == 0) begin
            return p ^ SYM_CASE_OFS;
        end
        return p;
    endfunction

    task automatic load_pattern(int len);
        logic [SYM_W-1:0] s;
        push_item(ACT_CLEAR, SYM_W'($urandom));
        cur_pat.delete();
        repeat (len) begin
            s = pick_symbol();
            push_item(ACT_APPEND, s);
            if (cur_pat.size() < MAX_PATTERN) begin
                cur_pat.push_back(s);
            end
        end
    endtask

    // One text followed by its end-of-text item. Most texts are derived from
    // the loaded pattern so that matches are common; the rest are random.
    task automatic run_text();
        logic [SYM_W-1:0] p;
        if ($urandom_range(0, 3) != 0) begin
            foreach (cur_pat[i]) begin
                p = cur_pat[i];
                if (p == SYM_ANY_RUN) begin
                    repeat ($urandom_range(0, 3)) push_item(ACT_TEXT, pick_symbol());
                end else if (p == SYM_ANY_ONE) begin
                    push_item(ACT_TEXT, SYM_W'($urandom));
                end else begin
                    push_item(ACT_TEXT, maybe_flip_case(p));
                end
            end
            if ($urandom_range(0, 5) == 0) begin
                push_item(ACT_TEXT, pick_symbol());
            end
        end else begin
            repeat ($urandom_range(0, 10)) push_item(ACT_TEXT, pick_symbol());
        end
        push_item(ACT_END, SYM_W'($urandom));
    endtask

    task automatic random_phase(int quota);
        int start;
        int pick;
        start = items_accepted;
        while (items_accepted - start < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                if ($urandom_range(0, 2) == 0) begin
                    load_pattern(($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_PATTERN)
                                                             : $urandom_range(0, 8));
                end
                repeat ($urandom_range(1, 3)) run_text();
            end else if (pick < 72) begin
                // Fill the store to the brim and often beyond it.
                load_pattern($urandom_range(MAX_PATTERN - 1, MAX_PATTERN + 4));
                run_text();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    push_item(t_action'($urandom_range(0, 3)), SYM_W'($urandom));
                end
            end
        end
    endtask

    // Case-folding setting for each random phase; both values appear twice or
    // more, and senders with and without gaps alternate.
    bit fold_plan [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    initial begin
        item_ch.valid           = 1'b0;
        item_ch.action          = ACT_CLEAR;
        item_ch.symbol          = SYM_NUL;
        cfg_ch.valid            = 1'b0;
        cfg_ch.case_insensitive = 1'b0;
        rst_n                   = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, with case folding at its reset value (off).
        // Empty pattern against the empty text, then against a one-byte text.
        push_item(ACT_END, SYM_NUL);
        push_item(ACT_TEXT, SYM_MID);
        push_item(ACT_END, SYM_ALL_ONES);
        // A lone star matches the empty text (zero-width star) and one zero byte.
        push_item(ACT_APPEND, SYM_ANY_RUN);
        push_item(ACT_END, SYM_NUL);
        push_item(ACT_TEXT, SYM_NUL);
        push_item(ACT_END, SYM_NUL);
        // Zero byte and all-ones byte as ordinary literals around a '?'.
        push_item(ACT_CLEAR, SYM_ALL_ONES);
        push_item(ACT_APPEND, SYM_NUL);
        push_item(ACT_APPEND, SYM_ANY_ONE);
        push_item(ACT_APPEND, SYM_ALL_ONES);
        push_item(ACT_TEXT, SYM_NUL);
        push_item(ACT_TEXT, SYM_HIGH_BIT);
        push_item(ACT_TEXT, SYM_ALL_ONES);
        push_item(ACT_END, SYM_NUL);
        // An append in the middle of a text restarts matching.
        push_item(ACT_CLEAR, SYM_NUL);
        push_item(ACT_APPEND, LOWER_A + 8'd1);
        push_item(ACT_TEXT, LOWER_A + 8'd1);
        push_item(ACT_APPEND, LOWER_A + 8'd2);
        push_item(ACT_TEXT, LOWER_A + 8'd1);
        push_item(ACT_TEXT, LOWER_A + 8'd2);
        push_item(ACT_END, SYM_NUL);
        // Letters of different case do not match while folding is off.
        push_item(ACT_CLEAR, SYM_NUL);
        push_item(ACT_APPEND, SYM_UPPER_A);
        push_item(ACT_TEXT, LOWER_A);
        push_item(ACT_END, SYM_NUL);
        settle();

        foreach (fold_plan[ph]) begin
            write_fold(fold_plan[ph]);
            gaps_on = ph[0];
            random_phase(PHASE_ITEMS);
            settle();
        end

        $display("Covered %0d input transfers and %0d verdicts (%0d matches, %0d overflowed).",
                 items_accepted, sb.verdicts_checked, sb.matches_seen, sb.overflows_seen);
        $display("Case folding written %0d times; long receiver hold applied: %0b.",
                 cfg_writes, hold_done);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
